/* hdl/drlma_pkg.sv */
package drlma_pkg;

    localparam int LINE_W    = 4;
    localparam int MUX_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int MUX_REG_W = 32;
    localparam int MAX_LINES = MUX_REG_W / MUX_W;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 2'd0,
        ST_BUSY     = 2'd1,
        ST_RELEASED = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ACQUIRE = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

endpackage

/* hdl/dma_request_line_mux_allocator.sv */
// Allocator for up to 16 shared DMA request lines, each with a use count and a
// 2-bit mux selection kept in a 32-bit channel mux register (line n at bits
// 2n+1:2n). Each acquire or release transaction returns exactly one result:
// status, the granted line, whether the mux register was rewritten, and the
// register value after the transaction. A transaction is held in an input
// register, the table is read and updated from it, and the result sits in an
// output register; a new transaction can be taken every cycle while the output
// side is not stalled. An accepted transaction passes through the input
// register and then the output register, where its result waits until the output
// side is ready. The sustained rate is one transaction per cycle while the output
// side is ready, set by the single read-modify-write of the line table.
module dma_request_line_mux_allocator #(
    parameter int NUM_LINES   = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [3:0] line_index, [5:4] mux_value, [7:6] zero
    input  logic [drlma_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] kind
    input  logic                            i_s_tuser,

    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [3:0] granted_line, [4] register_written, [36:5] mux_register_value,
    // [39:37] zero
    output logic [drlma_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [drlma_pkg::STATUS_W-1:0]  o_m_tuser
);

    localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam logic [drlma_pkg::LINE_W:0] NUM_LINES_C = (drlma_pkg::LINE_W + 1)'(NUM_LINES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Input stage.
    logic                           r_in_valid;
    drlma_pkg::t_kind               r_kind;
    logic [drlma_pkg::LINE_W-1:0]   r_line;
    logic [drlma_pkg::MUX_W-1:0]    r_mux;

    // Line table. The mux field of a line doubles as its owner value: both
    // are only ever set together, on a grant.
    logic [COUNT_WIDTH-1:0]         r_count     [NUM_LINES];
    logic [drlma_pkg::MUX_W-1:0]    r_mux_field [NUM_LINES];

    // Output stage.
    logic                           r_out_valid;
    drlma_pkg::t_status             r_status;
    logic [drlma_pkg::LINE_W-1:0]   r_granted;
    logic                           r_written;
    logic [drlma_pkg::MUX_REG_W-1:0] r_mux_reg;

    logic                           w_adv;
    logic                           w_in_range;
    logic [IDX_W-1:0]               w_idx;
    logic [COUNT_WIDTH-1:0]         w_count;
    logic [drlma_pkg::MUX_W-1:0]    w_field;
    drlma_pkg::t_status             w_status;
    logic                           w_write;
    logic                           w_inc;
    logic                           w_dec;
    logic [drlma_pkg::MUX_REG_W-1:0] w_mux_vec;
    logic [drlma_pkg::MUX_REG_W-1:0] w_mux_next;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    assign w_in_range = {1'b0, r_line} < NUM_LINES_C;
    assign w_idx      = r_line[IDX_W-1:0];
    assign w_count    = w_in_range ? r_count[w_idx] : '0;
    assign w_field    = w_in_range ? r_mux_field[w_idx] : '0;

    always_comb begin
        w_status = drlma_pkg::ST_BUSY;
        w_write  = 1'b0;
        w_inc    = 1'b0;
        w_dec    = 1'b0;
        case (r_kind)
            drlma_pkg::KIND_ACQUIRE: begin
                if (!w_in_range) begin
                    w_status = drlma_pkg::ST_BUSY;
                end else if (w_count != '0 && w_field != r_mux) begin
                    w_status = drlma_pkg::ST_BUSY;
                end else begin
                    w_status = drlma_pkg::ST_GRANTED;
                    w_write  = (w_count == '0);
                    w_inc    = (w_count != COUNT_MAX);
                end
            end
            drlma_pkg::KIND_RELEASE: begin
                if (!w_in_range || w_count == '0) begin
                    w_status = drlma_pkg::ST_UNUSED;
                end else begin
                    w_status = drlma_pkg::ST_RELEASED;
                    w_dec    = 1'b1;
                end
            end
            default: begin
                w_status = drlma_pkg::ST_BUSY;
            end
        endcase
    end

    // Current and post-update register images; fields of absent lines read 0.
    genvar g;
    generate
        for (g = 0; g < drlma_pkg::MAX_LINES; g++) begin : g_field
            if (g < NUM_LINES) begin : g_used
                assign w_mux_vec[2*g +: 2]  = r_mux_field[g];
                assign w_mux_next[2*g +: 2] = (w_write && w_idx == IDX_W'(g)) ?
                                              r_mux : r_mux_field[g];
            end else begin : g_unused
                assign w_mux_vec[2*g +: 2]  = '0;
                assign w_mux_next[2*g +: 2] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_kind <= drlma_pkg::t_kind'(i_s_tuser);
            r_line <= i_s_tdata[drlma_pkg::LINE_W-1:0];
            r_mux  <= i_s_tdata[drlma_pkg::LINE_W +: drlma_pkg::MUX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                r_count[i]     <= '0;
                r_mux_field[i] <= '0;
            end
        end else if (w_adv) begin
            if (w_inc) begin
                r_count[w_idx] <= w_count + COUNT_WIDTH'(1);
            end else if (w_dec) begin
                r_count[w_idx] <= w_count - COUNT_WIDTH'(1);
            end
            if (w_write) begin
                r_mux_field[w_idx] <= r_mux;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status  <= w_status;
            r_granted <= (w_status == drlma_pkg::ST_GRANTED) ? r_line : '0;
            r_written <= w_write;
            r_mux_reg <= w_mux_next;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {3'b000, r_mux_reg, r_written, r_granted};

    // Only a rewriting grant may change the mux register.
    a_mux_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && w_write) |=> $stable(w_mux_vec))
        else $error("mux register changed without a rewriting grant");

    // A refusal or release never reports a line or a register write.
    a_fields_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != drlma_pkg::ST_GRANTED) |->
        (r_granted == '0 && !r_written))
        else $error("granted_line or register_written set without a grant");

    // A full pipeline with a stalled output must not take another transaction.
    a_backpressure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while both stages are full");

    // A register write happens only on an acquire of a free line.
    a_write_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_write) |->
        (r_kind == drlma_pkg::KIND_ACQUIRE && w_in_range && w_count == '0))
        else $error("mux register write on a line in use");

endmodule
